// ===== hdl/robin_hood_hash_table_top_assert.svh =====
// assertion macros for the hash table
`ifndef ROBIN_HOOD_HASH_TABLE_TOP_ASSERT_SVH
`define ROBIN_HOOD_HASH_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RH_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RH_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define RH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/rhht_pkg.sv =====
`timescale 1ns / 1ps
package rhht_pkg;
  localparam logic [1:0] MODE_SEARCH = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_INSERTED  = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic CFG_MAX_ENTRIES = 1'b0;
  localparam logic CFG_HASH_MULT   = 1'b1;

  localparam logic [8:0] MAX_ENTRIES_RST = 9'd224;
  localparam logic [31:0] HASH_MULT_RST  = 32'd2654435769;

  // memory port request from the sequencer
  typedef struct packed {
    logic        we;
    logic [31:0] hash;
    logic [31:0] key;
    logic [31:0] value;
  } mem_wr_t;
endpackage

// ===== hdl/rhht_mem.sv =====
`timescale 1ns / 1ps
module rhht_mem #(
  parameter int AW = 8
) (
  input  logic                 clk,
  input  logic [AW-1:0]        rd_addr,
  input  logic [AW-1:0]        wr_addr,
  input  rhht_pkg::mem_wr_t    wr,
  output logic [31:0]          rd_hash,
  output logic [31:0]          rd_key,
  output logic [31:0]          rd_value
);
  logic [31:0] hash_mem  [2**AW];
  logic [31:0] key_mem   [2**AW];
  logic [31:0] value_mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      hash_mem[wr_addr]  <= wr.hash;
      key_mem[wr_addr]   <= wr.key;
      value_mem[wr_addr] <= wr.value;
    end
    rd_hash  <= hash_mem[rd_addr];
    rd_key   <= key_mem[rd_addr];
    rd_value <= value_mem[rd_addr];
  end
endmodule

// ===== hdl/robin_hood_hash_table_top.sv =====
`timescale 1ns / 1ps
// Robin Hood hash table, one request at a time. busy rises at the accepted
// start and falls as the out_valid strobe rises; the strobe lasts one cycle and
// cannot be held off, so the result must be taken when it shows. Each probed
// slot goes through the slot memory steps in order (address, registered read,
// write back). A remove that finds its key then runs a backward shift that goes
// through the same steps for every slot it looks at: one per moved entry plus
// the one that ends the shift. An insert refused at the load limit or with every
// slot taken skips the probe. Clear and reset sweep the memory one slot a cycle,
// during which start is not taken (busy high) but cfg writes are.
// The hash is key * hash_multiplier from one 32x32 multiplier, registered.
`include "robin_hood_hash_table_top_assert.svh"
module robin_hood_hash_table_top #(
  parameter int CAPACITY_LOG2 = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_value_out,
  output logic [7:0]  out_slot,
  output logic [8:0]  out_count,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);
  localparam int AW = CAPACITY_LOG2;
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] CAP = CW'(2**AW);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_HASH  = 10'b0000000010,
    S_RD    = 10'b0000000100,
    S_WAIT  = 10'b0000001000,
    S_EVAL  = 10'b0000010000,
    S_SHRD  = 10'b0000100000,
    S_SHWT  = 10'b0001000000,
    S_SHEV  = 10'b0010000000,
    S_SWEEP = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t       state_r, state_nxt;
  logic [8:0]   max_r;
  logic [31:0]  mult_r;
  logic [1:0]   mode_r;
  logic [31:0]  key_r, val_r, h_r;
  logic [31:0]  ch_r, ck_r, cv_r;
  logic         carry_r;
  logic [AW-1:0] idx_r, placed_r, empty_r;
  logic [CW-1:0] n_r, plen_r, cnt_r;
  logic [2:0]   st_r;
  logic [31:0]  vo_r;
  logic [AW-1:0] so_r;
  logic         ov_r;

  logic [AW-1:0] rd_addr, wr_addr;
  rhht_pkg::mem_wr_t wr;
  logic [31:0]  rh, rk, rv;

  rhht_mem #(.AW(AW)) u_mem (
    .clk(clk), .rd_addr(rd_addr), .wr_addr(wr_addr), .wr(wr),
    .rd_hash(rh), .rd_key(rk), .rd_value(rv)
  );

  // single multiplier, product registered in S_HASH
  logic [31:0] prod;
  assign prod = 32'(key_r * mult_r);

  logic [AW-1:0] home_dist, nxt_idx;
  assign home_dist = AW'(idx_r - rh[AW-1:0]);
  assign nxt_idx   = AW'(idx_r + 1'b1);
  logic hit;
  assign hit = (rh == h_r) && (rk == key_r);

  // insert refused at the load limit or with every slot taken
  logic full_req;
  assign full_req = (mode_r == rhht_pkg::MODE_INSERT) &&
                    ((32'(cnt_r) >= 32'(max_r)) || (cnt_r >= CAP));

  assign rd_addr = idx_r;

  always_comb begin
    state_nxt = state_r;
    wr = '0;
    wr_addr = idx_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = (in_mode == rhht_pkg::MODE_CLEAR) ? S_SWEEP : S_HASH;
      S_HASH: state_nxt = full_req ? S_DONE : S_RD;
      S_RD:   state_nxt = S_WAIT;
      S_WAIT: state_nxt = S_EVAL;
      S_EVAL: begin
        if (mode_r == rhht_pkg::MODE_INSERT) begin
          if (rh == 32'd0) begin
            wr = '{we: 1'b1, hash: ch_r, key: ck_r, value: cv_r};
            state_nxt = S_DONE;
          end else if (!carry_r && hit) begin
            state_nxt = S_DONE;
          end else begin
            if (CW'(home_dist) < plen_r)
              wr = '{we: 1'b1, hash: ch_r, key: ck_r, value: cv_r};
            state_nxt = S_RD;
          end
        end else begin
          if (rh == 32'd0 || (!hit && n_r == CAP - 1'b1)) state_nxt = S_DONE;
          else if (hit) begin
            if (mode_r == rhht_pkg::MODE_REMOVE) begin
              wr = '{we: 1'b1, hash: 32'd0, key: rk, value: rv};
              state_nxt = S_SHRD;
            end else state_nxt = S_DONE;
          end else state_nxt = S_RD;
        end
      end
      S_SHRD: state_nxt = S_SHWT;
      S_SHWT: state_nxt = S_SHEV;
      S_SHEV: begin
        wr_addr = empty_r;
        if (rh == 32'd0 || home_dist == '0 || n_r == CAP) begin
          // shift ends: free the last hole
          wr = '{we: 1'b1, hash: 32'd0, key: 32'd0, value: 32'd0};
          state_nxt = S_DONE;
        end else begin
          // move next entry back into the hole, its old slot is the new hole
          wr = '{we: 1'b1, hash: rh, key: rk, value: rv};
          state_nxt = S_SHRD;
        end
      end
      S_SWEEP: begin
        wr = '{we: 1'b1, hash: 32'd0, key: 32'd0, value: 32'd0};
        if (idx_r == '1) state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      idx_r   <= '0;
      max_r   <= rhht_pkg::MAX_ENTRIES_RST;
      mult_r  <= rhht_pkg::HASH_MULT_RST;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      mode_r  <= rhht_pkg::MODE_CLEAR;
      st_r    <= rhht_pkg::ST_NOT_FOUND;
      vo_r    <= '0;
      so_r    <= '0;
      carry_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // the reset sweep ends without a result, a clear item ends with one
      ov_r    <= (state_r == S_DONE) &&
                 ((mode_r != rhht_pkg::MODE_CLEAR) || (st_r == rhht_pkg::ST_REMOVED));
      if (cfg_we) begin
        if (cfg_index == rhht_pkg::CFG_MAX_ENTRIES) max_r <= cfg_wdata[8:0];
        else mult_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: if (start) begin
          mode_r <= in_mode; key_r <= in_key; val_r <= in_value;
          idx_r <= '0; n_r <= '0; plen_r <= '0; carry_r <= 1'b0;
          vo_r <= '0; so_r <= '0;
          if (in_mode == rhht_pkg::MODE_CLEAR) begin
            st_r <= rhht_pkg::ST_REMOVED; cnt_r <= '0;
          end
        end
        S_HASH: begin
          h_r  <= (prod == 32'd0) ? 32'hFFFF_FFFF : prod;
          ch_r <= (prod == 32'd0) ? 32'hFFFF_FFFF : prod;
          ck_r <= key_r; cv_r <= val_r;
          idx_r <= (prod == 32'd0) ? '1 : prod[AW-1:0];
          st_r <= full_req ? rhht_pkg::ST_FULL : rhht_pkg::ST_NOT_FOUND;
        end
        S_EVAL: begin
          if (mode_r == rhht_pkg::MODE_INSERT) begin
            if (rh == 32'd0) begin
              st_r <= rhht_pkg::ST_INSERTED; vo_r <= val_r;
              so_r <= carry_r ? placed_r : idx_r;
              cnt_r <= cnt_r + 1'b1;
            end else if (!carry_r && hit) begin
              st_r <= rhht_pkg::ST_FOUND; vo_r <= rv; so_r <= idx_r;
            end else begin
              if (CW'(home_dist) < plen_r) begin
                ch_r <= rh; ck_r <= rk; cv_r <= rv;
                if (!carry_r) begin
                  carry_r <= 1'b1; placed_r <= idx_r;
                end
                plen_r <= CW'(home_dist) + 1'b1;
              end else plen_r <= plen_r + 1'b1;
              idx_r <= nxt_idx;
            end
          end else if (rh != 32'd0 && hit) begin
            st_r <= (mode_r == rhht_pkg::MODE_REMOVE) ? rhht_pkg::ST_REMOVED
                                                       : rhht_pkg::ST_FOUND;
            vo_r <= rv; so_r <= idx_r;
            if (mode_r == rhht_pkg::MODE_REMOVE) begin
              empty_r <= idx_r; idx_r <= nxt_idx; n_r <= CW'(1);
              if (cnt_r != '0) cnt_r <= cnt_r - 1'b1;
            end
          end else begin
            idx_r <= nxt_idx; n_r <= n_r + 1'b1;
          end
        end
        S_SHEV: begin
          if (!(rh == 32'd0 || home_dist == '0 || n_r == CAP)) begin
            empty_r <= idx_r; idx_r <= nxt_idx; n_r <= n_r + 1'b1;
          end
        end
        S_SWEEP: idx_r <= nxt_idx;
        default: ;
      endcase
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = ov_r;
  assign out_status    = st_r;
  assign out_value_out = vo_r;
  assign out_slot      = 8'(so_r);
  assign out_count     = 9'(cnt_r);

  `RH_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "busy not raised")
  `RH_ASSERT_IMPL(a_cnt_cap, clk, rst_n, cnt_r <= CAP, "count above capacity")
  `RH_ASSERT_NEXT(a_out_idle, clk, rst_n, out_valid, !out_valid, "strobe too long")
endmodule

// ===== dv/hash_table_checker.sv =====
`timescale 1ns / 1ps
module hash_table_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  input  logic        out_valid,
  input  logic [2:0]  out_status,
  input  logic [31:0] out_value_out,
  input  logic [7:0]  out_slot,
  input  logic [8:0]  out_count,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          errors,
  output int          pending,
  output int          checked
);

  localparam int SLOTS = 256;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] value;
    logic [7:0]  slot;
    logic [8:0]  count;
  } lookup_result_t;

  lookup_result_t result_q[$];

  logic [8:0]  load_limit;
  logic [31:0] multiplier;
  logic [31:0] tbl_hash [SLOTS];
  logic [31:0] tbl_key  [SLOTS];
  logic [31:0] tbl_val  [SLOTS];
  logic [8:0]  entries;

  function automatic logic [31:0] key_to_hash(logic [31:0] k);
    logic [63:0] prod;
    prod = 64'(k) * 64'(multiplier);
    return (prod[31:0] == 32'd0) ? 32'hFFFF_FFFF : prod[31:0];
  endfunction

  // index of the live slot holding the key, or -1
  function automatic int locate(logic [31:0] k, logic [31:0] h);
    logic [7:0] idx;
    idx = h[7:0];
    for (int n = 0; n < SLOTS; n++) begin
      if (tbl_hash[idx] == 32'd0) return -1;
      if (tbl_hash[idx] == h && tbl_key[idx] == k) return int'(idx);
      idx = idx + 8'd1;
    end
    return -1;
  endfunction

  function automatic lookup_result_t apply_request(logic [1:0] md, logic [31:0] k,
                                                   logic [31:0] v);
    lookup_result_t r;
    logic [31:0] h, ch, ck, cv, th, tk, tv;
    logic [7:0]  idx, hole, nx, placed, home_dist, plen;
    logic        carrying;
    int          pos;
    r = '{status: rhht_pkg::ST_NOT_FOUND, value: 32'd0, slot: 8'd0, count: 9'd0};
    if (md == rhht_pkg::MODE_CLEAR) begin
      foreach (tbl_hash[i]) tbl_hash[i] = 32'd0;
      entries = 9'd0;
      r.status = rhht_pkg::ST_REMOVED;
    end else begin
      h = key_to_hash(k);
      if (md == rhht_pkg::MODE_SEARCH) begin
        pos = locate(k, h);
        if (pos >= 0) begin
          r.status = rhht_pkg::ST_FOUND;
          r.value  = tbl_val[pos];
          r.slot   = pos[7:0];
        end
      end else if (md == rhht_pkg::MODE_REMOVE) begin
        pos = locate(k, h);
        if (pos >= 0) begin
          r.status = rhht_pkg::ST_REMOVED;
          r.value  = tbl_val[pos];
          r.slot   = pos[7:0];
          hole = pos[7:0];
          tbl_hash[hole] = 32'd0;
          // backward shift until a free slot or an entry at home
          for (int n = 1; n < SLOTS; n++) begin
            nx = hole + 8'd1;
            if (tbl_hash[nx] == 32'd0) break;
            if (nx == tbl_hash[nx][7:0]) break;
            tbl_hash[hole] = tbl_hash[nx];
            tbl_key[hole]  = tbl_key[nx];
            tbl_val[hole]  = tbl_val[nx];
            tbl_hash[nx]   = 32'd0;
            hole = nx;
          end
          if (entries > 0) entries = entries - 9'd1;
        end
      end else if (entries >= load_limit || entries >= 9'(SLOTS)) begin
        r.status = rhht_pkg::ST_FULL;
      end else begin
        ch = h; ck = k; cv = v;
        carrying = 1'b0;
        placed = 8'd0;
        idx = h[7:0];
        plen = 8'd0;
        for (int n = 0; n < SLOTS; n++) begin
          if (tbl_hash[idx] == 32'd0) begin
            tbl_hash[idx] = ch;
            tbl_key[idx]  = ck;
            tbl_val[idx]  = cv;
            if (!carrying) placed = idx;
            entries = entries + 9'd1;
            r.status = rhht_pkg::ST_INSERTED;
            r.value  = v;
            r.slot   = placed;
            break;
          end
          if (!carrying && tbl_hash[idx] == h && tbl_key[idx] == k) begin
            r.status = rhht_pkg::ST_FOUND;
            r.value  = tbl_val[idx];
            r.slot   = idx;
            break;
          end
          home_dist = idx - tbl_hash[idx][7:0];
          // resident is richer than the carried entry: swap and carry it on
          if (home_dist < plen) begin
            th = tbl_hash[idx]; tk = tbl_key[idx]; tv = tbl_val[idx];
            tbl_hash[idx] = ch; tbl_key[idx] = ck; tbl_val[idx] = cv;
            ch = th; ck = tk; cv = tv;
            if (!carrying) begin
              carrying = 1'b1;
              placed = idx;
            end
            plen = home_dist;
          end
          idx = idx + 8'd1;
          plen = plen + 8'd1;
        end
      end
    end
    r.count = entries;
    return r;
  endfunction

  assign pending = result_q.size();

  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (!rst_n) begin
      load_limit <= rhht_pkg::MAX_ENTRIES_RST;
      multiplier <= rhht_pkg::HASH_MULT_RST;
      foreach (tbl_hash[i]) tbl_hash[i] = 32'd0;
      entries = 9'd0;
      result_q.delete();
      errors <= 0;
      checked <= 0;
    end else begin
      if (out_valid) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d value=%h slot=%0d count=%0d",
                   $time, out_status, out_value_out, out_slot, out_count);
          errors <= errors + 1;
        end else begin
          exp_r = result_q.pop_front();
          checked <= checked + 1;
          if (out_status !== exp_r.status || out_value_out !== exp_r.value ||
              out_slot !== exp_r.slot || out_count !== exp_r.count) begin
            $display("%0t: mismatch expected status=%0d value=%h slot=%0d count=%0d",
                     $time, exp_r.status, exp_r.value, exp_r.slot, exp_r.count);
            $display("%0t:          actual   status=%0d value=%h slot=%0d count=%0d",
                     $time, out_status, out_value_out, out_slot, out_count);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy)
        result_q.push_back(apply_request(in_mode, in_key, in_value));
      if (cfg_we) begin
        if (cfg_index == rhht_pkg::CFG_MAX_ENTRIES) load_limit <= cfg_wdata[8:0];
        else multiplier <= cfg_wdata;
      end
    end
  end

endmodule

// ===== dv/tb_robin_hood_hash_table_top.sv =====
`timescale 1ns / 1ps
module tb_robin_hood_hash_table_top;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_mode;
  logic [31:0] in_key;
  logic [31:0] in_value;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_value_out;
  logic [7:0]  out_slot;
  logic [8:0]  out_count;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  int          errors;
  int          pending;
  int          checked;

  int          sent_by_mode [4];
  logic [31:0] key_pool [64];
  int          gap_pct;

  robin_hood_hash_table_top dut (.*);

  hash_table_checker chk (.*);

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // hard stop in case the block hangs
  initial begin
    #200_000_000;
    $display("Some tests failed");
    $finish;
  end

  // one item: wait for idle at a falling edge, hold start over one rising edge
  task automatic send_item(logic [1:0] md, logic [31:0] k, logic [31:0] v);
    @(negedge clk);
    while (busy) @(negedge clk);
    start    <= 1'b1;
    in_mode  <= md;
    in_key   <= k;
    in_value <= v;
    sent_by_mode[md]++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  // let every outstanding item complete, then add idle slack
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random sender idle gaps of random length, taken gap_pct percent of the time
  task automatic maybe_idle();
    if ($urandom_range(99) < gap_pct)
      repeat ($urandom_range(1, 18)) @(negedge clk);
  endtask

  task automatic refill_pool();
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = 32'd0;
    key_pool[1] = 32'hFFFF_FFFF;
  endtask

  // mostly pool keys so lookups hit; a few fully random keys; rare clears
  task automatic random_phase(int n, int clear_pct, bit hold_mid);
    int roll;
    logic [31:0] k;
    refill_pool();
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      k = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(63)];
      if (roll < clear_pct)      send_item(rhht_pkg::MODE_CLEAR, k, $urandom());
      else if (roll < 48)        send_item(rhht_pkg::MODE_INSERT, k, $urandom());
      else if (roll < 74)        send_item(rhht_pkg::MODE_SEARCH, k, $urandom());
      else                       send_item(rhht_pkg::MODE_REMOVE, k, $urandom());
      if (hold_mid && i == n / 2) drain();
      maybe_idle();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_mode   = rhht_pkg::MODE_SEARCH;
    in_key    = 32'd0;
    in_value  = 32'd0;
    cfg_we    = 1'b0;
    cfg_index = rhht_pkg::CFG_MAX_ENTRIES;
    cfg_wdata = 32'd0;
    gap_pct   = 0;
    foreach (sent_by_mode[i]) sent_by_mode[i] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extreme keys and values, key whose product is zero
    send_item(rhht_pkg::MODE_SEARCH, 32'd5, 32'd0);
    send_item(rhht_pkg::MODE_INSERT, 32'd0, 32'hFFFF_FFFF);
    send_item(rhht_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'd0);
    send_item(rhht_pkg::MODE_INSERT, 32'd0, 32'd123);  // present key keeps old value
    send_item(rhht_pkg::MODE_SEARCH, 32'd0, 32'd0);
    send_item(rhht_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 32'd0);
    send_item(rhht_pkg::MODE_REMOVE, 32'd77, 32'd0);   // absent
    send_item(rhht_pkg::MODE_SEARCH, 32'hFFFF_FFFF, 32'd0);

    // identity hash: forced collisions, displacement and backward shift
    write_reg(rhht_pkg::CFG_HASH_MULT, 32'd1);
    send_item(rhht_pkg::MODE_INSERT, 32'd1, 32'hA);
    send_item(rhht_pkg::MODE_INSERT, 32'd257, 32'hB);
    send_item(rhht_pkg::MODE_INSERT, 32'd2, 32'hC);
    send_item(rhht_pkg::MODE_INSERT, 32'd513, 32'hD);  // displaces key 2
    send_item(rhht_pkg::MODE_INSERT, 32'd255, 32'hE);
    send_item(rhht_pkg::MODE_INSERT, 32'd511, 32'hF);  // wraps past the last slot
    send_item(rhht_pkg::MODE_REMOVE, 32'd1, 32'd0);    // shifts the chain back
    send_item(rhht_pkg::MODE_SEARCH, 32'd2, 32'd0);
    send_item(rhht_pkg::MODE_SEARCH, 32'd513, 32'd0);
    send_item(rhht_pkg::MODE_CLEAR, 32'd0, 32'd0);

    // load limit zero, then a tiny limit hit by a new and a present key
    write_reg(rhht_pkg::CFG_MAX_ENTRIES, 32'd0);
    send_item(rhht_pkg::MODE_INSERT, 32'd9, 32'd9);
    write_reg(rhht_pkg::CFG_MAX_ENTRIES, 32'd2);
    send_item(rhht_pkg::MODE_INSERT, 32'd9, 32'd9);
    send_item(rhht_pkg::MODE_INSERT, 32'd10, 32'd10);
    send_item(rhht_pkg::MODE_INSERT, 32'd11, 32'd11);
    send_item(rhht_pkg::MODE_INSERT, 32'd9, 32'd1);
    send_item(rhht_pkg::MODE_CLEAR, 32'd0, 32'd0);

    // random: reset-like settings with idling
    gap_pct = 30;
    write_reg(rhht_pkg::CFG_MAX_ENTRIES, 32'(rhht_pkg::MAX_ENTRIES_RST));
    write_reg(rhht_pkg::CFG_HASH_MULT, rhht_pkg::HASH_MULT_RST);
    random_phase(160, 2, 1'b1);

    // tight limit, random odd multiplier
    write_reg(rhht_pkg::CFG_MAX_ENTRIES, 32'd16);
    write_reg(rhht_pkg::CFG_HASH_MULT, $urandom() | 32'd1);
    random_phase(120, 2, 1'b0);

    // zero multiplier: one long chain, kept short by the limit
    write_reg(rhht_pkg::CFG_MAX_ENTRIES, 32'd24);
    write_reg(rhht_pkg::CFG_HASH_MULT, 32'd0);
    random_phase(80, 3, 1'b0);

    // limit above capacity: 262 inserts fill every slot and go past it
    gap_pct = 10;
    write_reg(rhht_pkg::CFG_MAX_ENTRIES, 32'd511);
    write_reg(rhht_pkg::CFG_HASH_MULT, $urandom());
    send_item(rhht_pkg::MODE_CLEAR, 32'd0, 32'd0);
    for (int i = 0; i < 262; i++) begin
      send_item(rhht_pkg::MODE_INSERT, $urandom(), $urandom());
      maybe_idle();
    end
    random_phase(40, 0, 1'b0);

    // full capacity limit, all-ones multiplier
    gap_pct = 30;
    write_reg(rhht_pkg::CFG_MAX_ENTRIES, 32'd256);
    write_reg(rhht_pkg::CFG_HASH_MULT, 32'hFFFF_FFFF);
    random_phase(100, 1, 1'b0);

    // last part back to back, no idling
    gap_pct = 0;
    write_reg(rhht_pkg::CFG_MAX_ENTRIES, 32'd64);
    write_reg(rhht_pkg::CFG_HASH_MULT, $urandom() | 32'd1);
    random_phase(100, 2, 1'b0);

    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);

    $display("covered %0d searches, %0d inserts, %0d removes, %0d clears",
             sent_by_mode[rhht_pkg::MODE_SEARCH], sent_by_mode[rhht_pkg::MODE_INSERT],
             sent_by_mode[rhht_pkg::MODE_REMOVE], sent_by_mode[rhht_pkg::MODE_CLEAR]);
    $display("%0d results checked across several load limit and multiplier settings",
             checked);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
